// ----- design/vector_signed_angle_top_assert.svh -----
// Assertion macros for the vector signed angle block.
// Used by vector_signed_angle_top.sv; expects clk and rst_n in scope.
`ifndef VECTOR_SIGNED_ANGLE_TOP_ASSERT_SVH
`define VECTOR_SIGNED_ANGLE_TOP_ASSERT_SVH

// Check that a consequence holds in the same cycle as its antecedent
`define VSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequence holds in the cycle after its antecedent
`define VSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vsa_pkg.sv -----
// Types and constants shared by the vector signed angle pipeline.
// No dependencies; used by vsa_isqrt, vsa_cordic and the top level.
package vsa_pkg;

  localparam int COMP_W       = 16;
  localparam int PROD_W       = 2 * COMP_W;
  localparam int DOT_W        = PROD_W + 2;
  localparam int CRS_W        = PROD_W + 1;
  localparam int MAG_W        = DOT_W;
  localparam int NRM_W        = 31;
  localparam int SHIFT_W      = $clog2(MAG_W - NRM_W + 1);
  localparam int SQ_W         = 2 * NRM_W;
  localparam int SUMSQ_W      = SQ_W + 2;
  localparam int ROOT_W       = SUMSQ_W / 2;
  localparam int REM_W        = ROOT_W + 3;
  localparam int AXP_W        = COMP_W + NRM_W + 1;
  localparam int AXS_W        = AXP_W + 2;
  localparam int CORDIC_W     = ROOT_W + 4;
  localparam int CORDIC_STEPS = 17;
  localparam int ATAN_W       = 17;
  localparam int ACC_W        = 19;
  localparam int ACCU_W       = 18;
  localparam int ANGLE_W      = 16;
  localparam int ACC_PI       = 205887;
  localparam int ACC_HALF_PI  = 102944;
  localparam int ANGLE_MAX    = 25736;
  localparam int ANGLE_MIN    = -25736;

  typedef struct packed {
    logic signed [COMP_W-1:0] a_x;
    logic signed [COMP_W-1:0] a_y;
    logic signed [COMP_W-1:0] a_z;
    logic signed [COMP_W-1:0] b_x;
    logic signed [COMP_W-1:0] b_y;
    logic signed [COMP_W-1:0] b_z;
    logic signed [COMP_W-1:0] axis_x;
    logic signed [COMP_W-1:0] axis_y;
    logic signed [COMP_W-1:0] axis_z;
    logic                     use_axis;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      degenerate;
  } out_t;

  // Per-item control carried alongside the root and CORDIC pipelines
  typedef struct packed {
    logic             dot_neg;
    logic [NRM_W-1:0] dot_mag;
    logic             neg_out;
    logic             degenerate;
    logic             null_vec;
  } side_t;

  // Arctangent of 2^-i in units of 2^-16 radian
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = ATAN_W'(51472);
      5'd1:    v = ATAN_W'(30386);
      5'd2:    v = ATAN_W'(16055);
      5'd3:    v = ATAN_W'(8150);
      5'd4:    v = ATAN_W'(4091);
      5'd5:    v = ATAN_W'(2047);
      5'd6:    v = ATAN_W'(1024);
      5'd7:    v = ATAN_W'(512);
      5'd8:    v = ATAN_W'(256);
      5'd9:    v = ATAN_W'(128);
      5'd10:   v = ATAN_W'(64);
      5'd11:   v = ATAN_W'(32);
      5'd12:   v = ATAN_W'(16);
      5'd13:   v = ATAN_W'(8);
      5'd14:   v = ATAN_W'(4);
      5'd15:   v = ATAN_W'(2);
      5'd16:   v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/vector_signed_angle_top.sv -----
// From input acceptance to out_valid: 5 front stages, 32 root stages, 17 CORDIC
// stages, output register. Throughput: one item per cycle when the skid is empty.
// The square root and CORDIC pipelines, one bit or rotation per stage, set the depth.
// A one-item skid stage behind the output register keeps in_ready registered.
// Reset (rst_n, synchronous) clears all valid bits; datapath registers hold junk.
`include "vector_signed_angle_top_assert.svh"

module vector_signed_angle_top import vsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic en;

  // Stage 1: products
  logic                     v1_r;
  logic signed [PROD_W-1:0] pd1_r [3];
  logic signed [PROD_W-1:0] pc1_r [6];
  logic signed [COMP_W-1:0] ax1_r [3];
  logic                     use1_r;
  logic                     deg1_r;

  // Stage 2: dot and cross sums
  logic                     v2_r;
  logic signed [DOT_W-1:0]  dot2_r;
  logic signed [CRS_W-1:0]  cr2_r [3];
  logic signed [COMP_W-1:0] ax2_r [3];
  logic                     use2_r;
  logic                     deg2_r;

  // Stage 3: normalised magnitudes
  logic [MAG_W-1:0]         dmag;
  logic [MAG_W-1:0]         cmag [3];
  logic [MAG_W-1:0]         all_or;
  logic [SHIFT_W-1:0]       sh;
  logic                     v3_r;
  logic                     dneg3_r;
  logic [NRM_W-1:0]         dnrm3_r;
  logic                     cneg3_r [3];
  logic [NRM_W-1:0]         cnrm3_r [3];
  logic signed [COMP_W-1:0] ax3_r [3];
  logic                     use3_r;
  logic                     deg3_r;
  logic                     null3_r;

  // Stage 4: squares and axis products
  logic signed [NRM_W:0]    csgn [3];
  logic                     v4_r;
  logic [SQ_W-1:0]          sq4_r [3];
  logic signed [AXP_W-1:0]  axp4_r [3];
  logic                     dneg4_r;
  logic [NRM_W-1:0]         dnrm4_r;
  logic                     use4_r;
  logic                     deg4_r;
  logic                     null4_r;

  // Stage 5: sum of squares and sign of axis . cross
  logic signed [AXS_W-1:0]  axs;
  logic                     v5_r;
  logic [SUMSQ_W-1:0]       sumsq5_r;
  side_t                    side5_r;

  // Root and CORDIC pipelines
  logic                     sq_vld;
  logic [ROOT_W-1:0]        sq_root;
  side_t                    sq_side;
  logic                     cd_vld;
  logic signed [ACC_W-1:0]  cd_acc;
  side_t                    cd_side;

  // Result and output stage
  logic [ACCU_W-1:0]        acl;
  logic [ACCU_W-1:0]        afl;
  logic [ACCU_W-1:0]        rnd;
  logic signed [ANGLE_W-1:0] amag;
  out_t                     res;
  logic                     out_v_r;
  out_t                     out_r;
  logic                     skid_v_r;
  out_t                     skid_r;

  // Advance the whole pipeline unless the skid stage holds an item
  assign en       = !skid_v_r;
  assign in_ready = en;

  // Stage 1: form the nine component products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd1_r[0] <= PROD_W'(in_data.a_x) * PROD_W'(in_data.b_x);
      pd1_r[1] <= PROD_W'(in_data.a_y) * PROD_W'(in_data.b_y);
      pd1_r[2] <= PROD_W'(in_data.a_z) * PROD_W'(in_data.b_z);
      pc1_r[0] <= PROD_W'(in_data.a_y) * PROD_W'(in_data.b_z);
      pc1_r[1] <= PROD_W'(in_data.a_z) * PROD_W'(in_data.b_y);
      pc1_r[2] <= PROD_W'(in_data.a_z) * PROD_W'(in_data.b_x);
      pc1_r[3] <= PROD_W'(in_data.a_x) * PROD_W'(in_data.b_z);
      pc1_r[4] <= PROD_W'(in_data.a_x) * PROD_W'(in_data.b_y);
      pc1_r[5] <= PROD_W'(in_data.a_y) * PROD_W'(in_data.b_x);
      ax1_r[0] <= in_data.axis_x;
      ax1_r[1] <= in_data.axis_y;
      ax1_r[2] <= in_data.axis_z;
      use1_r   <= in_data.use_axis;
      deg1_r   <= (in_data.a_x == '0 && in_data.a_y == '0 && in_data.a_z == '0) ||
                  (in_data.b_x == '0 && in_data.b_y == '0 && in_data.b_z == '0);
    end
  end

  // Stage 2: sum the dot product and the cross components
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2_r <= DOT_W'(pd1_r[0]) + DOT_W'(pd1_r[1]) + DOT_W'(pd1_r[2]);
      for (int k = 0; k < 3; k++) begin
        cr2_r[k] <= CRS_W'(pc1_r[2*k]) - CRS_W'(pc1_r[2*k+1]);
        ax2_r[k] <= ax1_r[k];
      end
      use2_r <= use1_r;
      deg2_r <= deg1_r;
    end
  end

  // Stage 3: take magnitudes and shift all of them below 2^31 together
  always_comb begin
    dmag = MAG_W'($unsigned(dot2_r[DOT_W-1] ? -dot2_r : dot2_r));
    for (int k = 0; k < 3; k++) begin
      cmag[k] = MAG_W'($unsigned(cr2_r[k][CRS_W-1] ? -cr2_r[k] : cr2_r[k]));
    end
    all_or = dmag | cmag[0] | cmag[1] | cmag[2];
    sh = '0;
    for (int b = NRM_W; b < MAG_W; b++) begin
      if (all_or[b]) begin
        sh = SHIFT_W'(b - NRM_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg3_r <= dot2_r[DOT_W-1];
      dnrm3_r <= NRM_W'(dmag >> sh);
      for (int k = 0; k < 3; k++) begin
        cneg3_r[k] <= cr2_r[k][CRS_W-1];
        cnrm3_r[k] <= NRM_W'(cmag[k] >> sh);
        ax3_r[k]   <= ax2_r[k];
      end
      use3_r  <= use2_r;
      deg3_r  <= deg2_r;
      null3_r <= ((all_or >> sh) == '0);
    end
  end

  // Stage 4: square the cross components and weight them by the axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csgn[k] = cneg3_r[k] ? -$signed({1'b0, cnrm3_r[k]}) : $signed({1'b0, cnrm3_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq4_r[k]  <= SQ_W'(cnrm3_r[k]) * SQ_W'(cnrm3_r[k]);
        axp4_r[k] <= AXP_W'(ax3_r[k]) * AXP_W'(csgn[k]);
      end
      dneg4_r <= dneg3_r;
      dnrm4_r <= dnrm3_r;
      use4_r  <= use3_r;
      deg4_r  <= deg3_r;
      null4_r <= null3_r;
    end
  end

  // Stage 5: sum the squares and decide the sign of the result
  assign axs = AXS_W'(axp4_r[0]) + AXS_W'(axp4_r[1]) + AXS_W'(axp4_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sumsq5_r           <= SUMSQ_W'(sq4_r[0]) + SUMSQ_W'(sq4_r[1]) + SUMSQ_W'(sq4_r[2]);
      side5_r.dot_neg    <= dneg4_r;
      side5_r.dot_mag    <= dnrm4_r;
      side5_r.neg_out    <= use4_r && axs[AXS_W-1];
      side5_r.degenerate <= deg4_r;
      side5_r.null_vec   <= null4_r;
    end
  end

  // Length of the cross product
  vsa_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_rad    (sumsq5_r),
    .in_side   (side5_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Angle of (|dot|, |cross|)
  vsa_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_x      (sq_side.dot_mag),
    .in_y      (sq_root),
    .in_side   (sq_side),
    .out_valid (cd_vld),
    .out_acc   (cd_acc),
    .out_side  (cd_side)
  );

  // Clamp, fold obtuse angles into the upper half, round, sign; zero if degenerate/null
  always_comb begin
    if (cd_acc < 0) begin
      acl = '0;
    end else if (cd_acc > ACC_W'(ACC_HALF_PI)) begin
      acl = ACCU_W'(ACC_HALF_PI);
    end else begin
      acl = ACCU_W'(cd_acc);
    end
    afl  = cd_side.dot_neg ? ACCU_W'(ACC_PI) - acl : acl;
    rnd  = afl + ACCU_W'(4);
    amag = $signed(ANGLE_W'(rnd >> 3));
    res.degenerate = cd_side.degenerate;
    if (cd_side.degenerate || cd_side.null_vec) begin
      res.angle = '0;
    end else if (cd_side.neg_out) begin
      res.angle = -amag;
    end else begin
      res.angle = amag;
    end
  end

  // Output register with a one-item skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || cd_vld;
      skid_v_r <= 1'b0;
    end else if (cd_vld && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : res;
    end
    if (out_v_r && !out_ready && en) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `VSA_ASSERT_NOW(a_skid_needs_out, skid_v_r, out_v_r, "skid item without output item")
  `VSA_ASSERT_NEXT(a_skid_drains, skid_v_r && out_ready, !skid_v_r, "skid item not drained")
  `VSA_ASSERT_NOW(a_degen_zero, out_v_r && out_r.degenerate, out_r.angle == '0,
                  "degenerate angle not zero")
  `VSA_ASSERT_NOW(a_angle_range, out_v_r,
                  ($signed(out_r.angle) <= ANGLE_MAX) && ($signed(out_r.angle) >= ANGLE_MIN),
                  "angle out of range")

endmodule

// ----- design/vsa_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on vsa_pkg for widths and the side_t control struct.
module vsa_isqrt import vsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SUMSQ_W-1:0] in_rad,
  input  side_t              in_side,
  output logic               out_valid,
  output logic [ROOT_W-1:0]  out_root,
  output side_t              out_side
);

  logic [SUMSQ_W-1:0] rad_w  [0:ROOT_W];
  logic [REM_W-1:0]   rem_w  [0:ROOT_W];
  logic [ROOT_W-1:0]  root_w [0:ROOT_W];
  side_t              side_w [0:ROOT_W];
  logic               vld_w  [0:ROOT_W];

  assign rad_w[0]  = in_rad;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = in_side;
  assign vld_w[0]  = in_valid;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic [REM_W-1:0]   rem_nxt;
    logic [ROOT_W-1:0]  root_nxt;
    logic [SUMSQ_W-1:0] rad_nxt;
    logic [REM_W-1:0]   rem_r;
    logic [ROOT_W-1:0]  root_r;
    logic [SUMSQ_W-1:0] rad_r;
    side_t              side_r;
    logic               vld_r;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh  = {rem_w[i][REM_W-3:0], rad_w[i][SUMSQ_W-1 -: 2]};
      trial   = REM_W'({root_w[i], 2'b01});
      rad_nxt = {rad_w[i][SUMSQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_w[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_w[i][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        rad_r  <= rad_nxt;
        side_r <= side_w[i];
      end
    end

    assign rem_w[i+1]  = rem_r;
    assign root_w[i+1] = root_r;
    assign rad_w[i+1]  = rad_r;
    assign side_w[i+1] = side_r;
    assign vld_w[i+1]  = vld_r;
  end

  assign out_valid = vld_w[ROOT_W];
  assign out_root  = root_w[ROOT_W];
  assign out_side  = side_w[ROOT_W];

endmodule

// ----- design/vsa_cordic.sv -----
// Pipelined CORDIC in vectoring mode, one rotation per stage.
// Depends on vsa_pkg for widths, the arctangent table and side_t.
module vsa_cordic import vsa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [NRM_W-1:0]        in_x,
  input  logic [ROOT_W-1:0]       in_y,
  input  side_t                   in_side,
  output logic                    out_valid,
  output logic signed [ACC_W-1:0] out_acc,
  output side_t                   out_side
);

  logic signed [CORDIC_W-1:0] x_w   [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_w   [0:CORDIC_STEPS];
  logic signed [ACC_W-1:0]    acc_w [0:CORDIC_STEPS];
  side_t                      side_w[0:CORDIC_STEPS];
  logic                       vld_w [0:CORDIC_STEPS];

  assign x_w[0]    = $signed(CORDIC_W'(in_x));
  assign y_w[0]    = $signed(CORDIC_W'(in_y));
  assign acc_w[0]  = '0;
  assign side_w[0] = in_side;
  assign vld_w[0]  = in_valid;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ACC_W-1:0]    ang;
    logic signed [CORDIC_W-1:0] x_nxt;
    logic signed [CORDIC_W-1:0] y_nxt;
    logic signed [ACC_W-1:0]    acc_nxt;
    logic signed [CORDIC_W-1:0] x_r;
    logic signed [CORDIC_W-1:0] y_r;
    logic signed [ACC_W-1:0]    acc_r;
    side_t                      side_r;
    logic                       vld_r;

    // Rotate towards the x axis and accumulate the angle turned
    always_comb begin
      xs  = x_w[i] >>> i;
      ys  = y_w[i] >>> i;
      ang = $signed(ACC_W'(atan_lut(5'(i))));
      if (y_w[i] >= 0) begin
        x_nxt   = x_w[i] + ys;
        y_nxt   = y_w[i] - xs;
        acc_nxt = acc_w[i] + ang;
      end else begin
        x_nxt   = x_w[i] - ys;
        y_nxt   = y_w[i] + xs;
        acc_nxt = acc_w[i] - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        acc_r  <= acc_nxt;
        side_r <= side_w[i];
      end
    end

    assign x_w[i+1]    = x_r;
    assign y_w[i+1]    = y_r;
    assign acc_w[i+1]  = acc_r;
    assign side_w[i+1] = side_r;
    assign vld_w[i+1]  = vld_r;
  end

  assign out_valid = vld_w[CORDIC_STEPS];
  assign out_acc   = acc_w[CORDIC_STEPS];
  assign out_side  = side_w[CORDIC_STEPS];

endmodule

// ----- dv/vsa_angle_checker.sv -----
// Scoreboard for the vector signed angle block: predicts each angle, checks results.
// Depends on vsa_pkg for the item types; instantiated by tb_vector_signed_angle_top.
`timescale 1ns / 100ps

module vsa_angle_checker import vsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  // Arctangent of 2^-i, units of 2^-16 rad
  longint atan_steps [CORDIC_STEPS] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2, 1};
  out_t angle_queue [$];

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_t predict_angle(input in_t d);
    longint a [3], b [3], ax [3], cs [3];
    longint dotv, x, y, xs, ys, acc, ang, s;
    longint unsigned dmag, cmag [3], sumsq;
    bit dneg;
    bit cneg [3];
    out_t res;
    a = '{longint'(d.a_x), longint'(d.a_y), longint'(d.a_z)};
    b = '{longint'(d.b_x), longint'(d.b_y), longint'(d.b_z)};
    ax = '{longint'(d.axis_x), longint'(d.axis_y), longint'(d.axis_z)};
    res = '0;
    // zero-length vector: flag it, angle stays zero
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
      res.degenerate = 1'b1;
      return res;
    end
    dotv = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    cs[0] = a[1] * b[2] - a[2] * b[1];
    cs[1] = a[2] * b[0] - a[0] * b[2];
    cs[2] = a[0] * b[1] - a[1] * b[0];
    dneg = dotv < 0;
    dmag = dneg ? -dotv : dotv;
    for (int i = 0; i < 3; i++) begin
      cneg[i] = cs[i] < 0;
      cmag[i] = cneg[i] ? -cs[i] : cs[i];
    end
    // shift everything down together until it fits 31 bits
    while ((dmag | cmag[0] | cmag[1] | cmag[2]) >= (64'd1 << 31)) begin
      dmag = dmag >> 1;
      for (int i = 0; i < 3; i++) cmag[i] = cmag[i] >> 1;
    end
    if ((dmag | cmag[0] | cmag[1] | cmag[2]) == 0) return res;
    sumsq = cmag[0] * cmag[0] + cmag[1] * cmag[1] + cmag[2] * cmag[2];
    x = longint'(dmag);
    y = longint'(floor_sqrt(sumsq));
    acc = 0;
    // vectoring rotations towards the x axis
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + atan_steps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - atan_steps[i];
      end
    end
    if (acc < 0) acc = 0;
    if (acc > ACC_HALF_PI) acc = ACC_HALF_PI;
    if (dneg) acc = ACC_PI - acc;
    ang = (acc + 4) >>> 3;
    // sign from the axis against the truncated cross product
    if (d.use_axis) begin
      s = 0;
      for (int i = 0; i < 3; i++) s = s + ax[i] * (cneg[i] ? -longint'(cmag[i]) : longint'(cmag[i]));
      if (s < 0) ang = -ang;
    end
    res.angle = ang[ANGLE_W-1:0];
    return res;
  endfunction

  // Predict on input accept, compare on result accept
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
      angle_queue.delete();
    end else begin
      if (in_valid && in_ready) angle_queue.push_back(predict_angle(in_data));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (angle_queue.size() == 0) begin
          $error("unexpected result: angle %0d degenerate %0d",
                 out_data.angle, out_data.degenerate);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = angle_queue.pop_front();
          if (exp_res.angle !== out_data.angle || exp_res.degenerate !== out_data.degenerate)
            fail_count <= fail_count + 1;
          if (exp_res.angle !== out_data.angle)
            $error("angle: expected %0d, actual %0d", exp_res.angle, out_data.angle);
          if (exp_res.degenerate !== out_data.degenerate)
            $error("degenerate: expected %0d, actual %0d",
                   exp_res.degenerate, out_data.degenerate);
        end
      end
      pending <= angle_queue.size();
    end
  end

endmodule

// ----- dv/tb_vector_signed_angle_top.sv -----
// Testbench top for vector_signed_angle_top: clock, reset, stimulus and verdict.
// Depends on vsa_pkg, the block and vsa_angle_checker.
`timescale 1ns / 100ps

module tb_vector_signed_angle_top;
  import vsa_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 1450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count, pending, results_seen;
  int   send_idle_pct = 15;
  int   recv_idle_pct = 67;
  bit   hold_req = 1'b0;
  int   stall_cycles = 0;
  int   sent = 0;

  vector_signed_angle_top u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  vsa_angle_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      out_ready <= 1'b0;
      for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, idling first at the current rate, and hold it until taken
  task automatic send_vectors(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic in_t pack_vectors(input int ax_, ay, az, bx, by, bz,
                                       input int kx, ky, kz, input bit sgn);
    in_t v;
    v.a_x = ax_[15:0]; v.a_y = ay[15:0]; v.a_z = az[15:0];
    v.b_x = bx[15:0];  v.b_y = by[15:0]; v.b_z = bz[15:0];
    v.axis_x = kx[15:0]; v.axis_y = ky[15:0]; v.axis_z = kz[15:0];
    v.use_axis = sgn;
    return v;
  endfunction

  function automatic int small_comp();
    return $urandom_range(1024) - 512;
  endfunction

  // Mix of raw random items, small vectors, 2-D pairs, near-parallel and zero vectors
  function automatic in_t random_vectors();
    in_t v;
    int k;
    logic [159:0] raw;
    k = $urandom_range(99);
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    v = raw[$bits(in_t)-1:0];
    if (k < 40) begin
    end else if (k < 65) begin
      v = pack_vectors(small_comp(), small_comp(), small_comp(), small_comp(), small_comp(),
                       small_comp(), small_comp(), small_comp(), small_comp(),
                       1'($urandom_range(1)));
    end else if (k < 82) begin
      v.a_z = '0; v.b_z = '0;
      v.axis_x = '0; v.axis_y = '0; v.axis_z = 16'sd256;
      v.use_axis = 1'b1;
    end else if (k < 94) begin
      v.b_x = v.a_x + 16'($urandom_range(8)) - 16'sd4;
      v.b_y = v.a_y + 16'($urandom_range(8)) - 16'sd4;
      v.b_z = v.a_z + 16'($urandom_range(8)) - 16'sd4;
      if ($urandom_range(1)) begin
        v.b_x = -v.b_x; v.b_y = -v.b_y; v.b_z = -v.b_z;
      end
    end else if (k < 97) begin
      v.a_x = '0; v.a_y = '0; v.a_z = '0;
    end else begin
      v.b_x = '0; v.b_y = '0; v.b_z = '0;
    end
    return v;
  endfunction

  initial begin
    in_t directed [$];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero vectors, extremes, parallel, opposite, 2-D both turns
    directed.push_back(pack_vectors(0, 0, 0, 256, 0, 0, 0, 0, 256, 1));
    directed.push_back(pack_vectors(256, 0, 0, 0, 0, 0, 0, 0, 256, 0));
    directed.push_back(pack_vectors(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(pack_vectors(256, 0, 0, 512, 0, 0, 0, 0, 256, 1));
    directed.push_back(pack_vectors(256, 0, 0, -256, 0, 0, 0, 0, 256, 1));
    directed.push_back(pack_vectors(256, 0, 0, 0, 256, 0, 0, 0, 256, 1));
    directed.push_back(pack_vectors(0, 256, 0, 256, 0, 0, 0, 0, 256, 1));
    directed.push_back(pack_vectors(0, 256, 0, 256, 0, 0, 0, 0, 256, 0));
    directed.push_back(pack_vectors(256, 256, 0, -256, 1, 0, 0, 0, 256, 1));
    directed.push_back(pack_vectors(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, 1));
    directed.push_back(pack_vectors(32767, 32767, 32767, -32768, -32768, -32768,
                                    32767, 32767, 32767, 1));
    directed.push_back(pack_vectors(32767, -32768, 0, -32768, -32768, 32767,
                                    -32768, 32767, -1, 1));
    directed.push_back(pack_vectors(32767, 0, 0, 0, 32767, 0, 0, 0, -32768, 1));
    directed.push_back(pack_vectors(1, 0, 0, 0, 1, 0, 0, 0, -1, 1));
    directed.push_back(pack_vectors(32767, 32767, 32767, 32767, 32767, 32766, 1, 0, 0, 1));
    directed.push_back(pack_vectors(-1, -1, -1, 1, 1, 1, -1, -1, -1, 1));
    directed.push_back(pack_vectors(-1, 0, 0, 0, 0, 1, 0, -32768, 0, 1));
    foreach (directed[i]) send_vectors(directed[i]);

    // Three random phases with shifting idle rates
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 67; recv_idle_pct = 15;
      end else if (phase == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < RAND_ITEMS / 3; n++) send_vectors(random_vectors());
    end
    in_valid <= 1'b0;

    // Drain, then allow for pipeline latency
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d items (%0d results): zero, extreme, parallel, 2-D and random",
             sent, results_seen);
    $display("idle mixes 15/67, 67/15, 0/0, plus a %0d-cycle receiver hold-off", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
